/* hdl/sih_pkg.sv */
// Shared types and constants for the symbol intern hash table.
package sih_pkg;

  localparam int TABLE_SLOTS_DEF    = 64;
  localparam int MAX_NAME_BYTES_DEF = 32;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [6:0] LIMIT_RESET = 7'd48;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // The length field is wide enough for any legal buffer size.
  typedef struct packed {
    logic [31:0] hash;
    logic [8:0]  len;
  } sih_job_t;

  // Byte write from the front part into the name buffer.
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } sih_buf_wr_t;

endpackage

/* hdl/sih_front.sv */
// Front part: folds bytes into the hash, buffers them and issues lookup jobs.
module sih_front import sih_pkg::*; #(
  parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  name_byte,
  input  logic        has_byte,
  input  logic        is_last,
  output logic        push_pending,
  output logic        job_push,
  output sih_job_t    job,
  output sih_buf_wr_t buf_wr
);

  localparam int LW = $clog2(MAX_NAME_BYTES + 2);

  logic [31:0]   hash_r, hash_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          push_r, push_nxt;

  always_comb begin
    hash_nxt    = hash_r;
    len_nxt     = len_r;
    push_nxt    = push_r;
    buf_wr.en   = 1'b0;
    buf_wr.addr = 8'(len_r);
    buf_wr.data = name_byte;
    if (push_r) begin
      hash_nxt = FNV_BASIS;
      len_nxt  = '0;
      push_nxt = 1'b0;
    end else if (accept) begin
      if (has_byte) begin
        hash_nxt = 32'((hash_r ^ {24'd0, name_byte}) * FNV_PRIME);
        if (32'(len_r) < MAX_NAME_BYTES) begin
          buf_wr.en = 1'b1;
          len_nxt   = len_r + LW'(1);
        end else begin
          len_nxt = LW'(MAX_NAME_BYTES + 1);
        end
      end
      push_nxt = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
      len_r  <= '0;
      push_r <= 1'b0;
    end else begin
      hash_r <= hash_nxt;
      len_r  <= len_nxt;
      push_r <= push_nxt;
    end
  end

  assign push_pending = push_r;
  assign job_push     = push_r;
  assign job.hash     = hash_r;
  assign job.len      = 9'(len_r);

endmodule

/* hdl/sih_queue.sv */
// Two-entry job queue between the front and back parts.
module sih_queue import sih_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sih_job_t push_data,
  input  logic     pop,
  output logic     not_empty,
  output sih_job_t pop_data
);

  sih_job_t   mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push && cnt_r != 2'd2) mem_r[wr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && cnt_r != 2'd2) wr_r <= ~wr_r;
      if (pop && not_empty) rd_r <= ~rd_r;
      cnt_r <= cnt_r + 2'((push && cnt_r != 2'd2) ? 1 : 0)
                     - 2'((pop && not_empty) ? 1 : 0);
    end
  end

endmodule

/* hdl/sih_back.sv */
// Back part: hash reduction, linear probing, byte compare and insert.
module sih_back import sih_pkg::*; #(
  parameter int TABLE_SLOTS    = TABLE_SLOTS_DEF,
  parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [6:0]  insert_limit,
  input  sih_buf_wr_t buf_wr,
  input  logic        job_valid,
  input  sih_job_t    job_in,
  output logic        job_pop,
  output logic        busy,
  output logic        res_valid,
  output logic [5:0]  res_slot,
  output logic        res_is_new,
  output logic [1:0]  res_status
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int LW = $clog2(MAX_NAME_BYTES + 2);
  localparam int BW = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam int AW = $clog2(TABLE_SLOTS * MAX_NAME_BYTES);

  // Reciprocal of the slot count, rounded down. The quotient estimate it
  // gives is at most one below the true quotient, so one subtract finishes
  // the remainder.
  localparam logic [31:0] MODULUS = 32'(TABLE_SLOTS);
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(TABLE_SLOTS));

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_RED, S_FIX, S_PROBE, S_META, S_BREQ, S_BCMP, S_CREQ, S_CWR, S_RES
  } state_t;

  state_t        state_r;
  logic [31:0]   hash_r;
  logic [LW-1:0] len_r;
  logic [31:0]   quo_r, rem_r;
  logic [SW-1:0] pos_r;
  logic [CW-1:0] n_r, count_r;
  logic [BW-1:0] bi_r;
  logic [SW-1:0] slot_r;
  logic          new_r;
  logic [1:0]    status_r;
  logic [TABLE_SLOTS-1:0] valid_r;

  logic [31:0]   hash_mem [TABLE_SLOTS];
  logic [LW-1:0] len_mem  [TABLE_SLOTS];
  logic [7:0]    name_mem [TABLE_SLOTS * MAX_NAME_BYTES];
  logic [7:0]    buf_mem  [MAX_NAME_BYTES];
  logic [31:0]   hash_q;
  logic [LW-1:0] len_q;
  logic [7:0]    byte_q, buf_q;

  logic [63:0]   prod_w;
  logic [31:0]   rem_fix;
  logic [AW-1:0] naddr;
  logic          last_byte, can_insert, ins_now, cpy_now;

  assign prod_w  = {32'd0, hash_r} * {32'd0, RECIP};
  assign rem_fix = (rem_r >= MODULUS) ? rem_r - MODULUS : rem_r;
  assign naddr = AW'(pos_r) * AW'(MAX_NAME_BYTES) + AW'(bi_r);
  assign last_byte = (LW'(bi_r) + LW'(1) == len_r);
  assign can_insert = (32'(count_r) < 32'(insert_limit)) && (32'(count_r) < TABLE_SLOTS);
  assign ins_now = (state_r == S_PROBE) && !valid_r[pos_r] && can_insert;
  assign cpy_now = (state_r == S_CWR);

  // Table and buffer storage; reads are registered.
  always_ff @(posedge clk) begin
    if (buf_wr.en) buf_mem[buf_wr.addr[BW-1:0]] <= buf_wr.data;
    if (ins_now) begin
      hash_mem[pos_r] <= hash_r;
      len_mem[pos_r]  <= len_r;
    end
    if (cpy_now) name_mem[naddr] <= buf_q;
    hash_q <= hash_mem[pos_r];
    len_q  <= len_mem[pos_r];
    byte_q <= name_mem[naddr];
    buf_q  <= buf_mem[bi_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      count_r  <= '0;
      new_r    <= 1'b0;
      status_r <= ST_OK;
      slot_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            hash_r   <= job_in.hash;
            len_r    <= LW'(job_in.len);
            new_r    <= 1'b0;
            slot_r   <= '0;
            if (32'(job_in.len) > MAX_NAME_BYTES) begin
              status_r <= ST_TOO_LONG;
              state_r  <= S_RES;
            end else begin
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          quo_r   <= prod_w[63:32];
          state_r <= S_RED;
        end
        S_RED: begin
          rem_r   <= hash_r - quo_r * MODULUS;
          state_r <= S_FIX;
        end
        S_FIX: begin
          pos_r   <= SW'(rem_fix);
          n_r     <= '0;
          state_r <= S_PROBE;
        end
        S_PROBE: begin
          if (!valid_r[pos_r]) begin
            if (can_insert) begin
              valid_r[pos_r] <= 1'b1;
              count_r  <= count_r + CW'(1);
              slot_r   <= pos_r;
              new_r    <= 1'b1;
              status_r <= ST_OK;
              bi_r     <= '0;
              state_r  <= (len_r == '0) ? S_RES : S_CREQ;
            end else begin
              status_r <= ST_FULL;
              state_r  <= S_RES;
            end
          end else begin
            state_r <= S_META;
          end
        end
        S_META, S_BCMP: begin
          if (state_r == S_META && hash_q == hash_r && len_q == len_r && len_r == '0) begin
            slot_r   <= pos_r;
            status_r <= ST_OK;
            state_r  <= S_RES;
          end else if (state_r == S_META && hash_q == hash_r && len_q == len_r) begin
            bi_r    <= '0;
            state_r <= S_BREQ;
          end else if (state_r == S_BCMP && byte_q == buf_q && last_byte) begin
            slot_r   <= pos_r;
            status_r <= ST_OK;
            state_r  <= S_RES;
          end else if (state_r == S_BCMP && byte_q == buf_q) begin
            bi_r    <= bi_r + BW'(1);
            state_r <= S_BREQ;
          end else if (32'(n_r) == TABLE_SLOTS - 1) begin
            // Every slot probed without a match or an empty slot.
            status_r <= ST_FULL;
            state_r  <= S_RES;
          end else begin
            n_r     <= n_r + CW'(1);
            pos_r   <= (32'(pos_r) == TABLE_SLOTS - 1) ? '0 : pos_r + SW'(1);
            state_r <= S_PROBE;
          end
        end
        S_BREQ: state_r <= S_BCMP;
        S_CREQ: state_r <= S_CWR;
        S_CWR: begin
          if (last_byte) begin
            state_r <= S_RES;
          end else begin
            bi_r    <= bi_r + BW'(1);
            state_r <= S_CREQ;
          end
        end
        S_RES:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign job_pop    = (state_r == S_IDLE) && job_valid;
  assign busy       = (state_r != S_IDLE);
  assign res_valid  = (state_r == S_RES);
  assign res_slot   = 6'(slot_r);
  assign res_is_new = new_r;
  assign res_status = status_r;

endmodule

/* hdl/symbol_intern_hash_table.sv */
// Top level of the symbol intern hash table.
//
// A name is sent one byte per transfer on the in_ channel: a transfer happens
// at a clock edge where start is high and busy is low. in_has_byte marks a
// valid byte and in_is_last ends the name. Bytes of a name are taken one per
// cycle; each is folded into an FNV-1a hash by a single multiplier stage.
// After the last byte the front part hands a job to a two-entry queue and the
// back part reduces the hash modulo the slot count by a reciprocal multiply
// and one correcting subtract, then probes the table linearly: an empty slot
// ends the probe, while for an occupied slot the hash, length and name bytes
// are compared, all through registered memory ports. An insert copies the
// name into the table one byte at a time. busy stays high from the last byte
// until the result has been shown, so one name is processed at a time. The
// result appears on the out_ ports for exactly one cycle with out_valid high;
// the receiver cannot stall it. Reset sets the hash to the FNV offset basis,
// clears the length, entry count and slot valid bits and sets insert_limit to
// 48; no clearing pass is needed. cfg_we writes insert_limit; the user must
// use it only while the block is idle, which the block does not enforce.
module symbol_intern_hash_table import sih_pkg::*; #(
  parameter int TABLE_SLOTS    = TABLE_SLOTS_DEF,
  parameter int MAX_NAME_BYTES = MAX_NAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_name_byte,
  input  logic       in_has_byte,
  input  logic       in_is_last,
  output logic       out_valid,
  output logic [5:0] out_slot,
  output logic       out_is_new,
  output logic [1:0] out_status,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  logic [6:0]  insert_limit_r;
  logic        accept, push_pending, job_push, job_pop, q_not_empty, back_busy;
  sih_job_t    job_w, job_q;
  sih_buf_wr_t buf_wr;

  // The front part is held off while any name is still in flight.
  assign busy   = push_pending || q_not_empty || back_busy;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      insert_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      insert_limit_r <= cfg_wdata;
    end
  end

  sih_front #(.MAX_NAME_BYTES(MAX_NAME_BYTES)) u_front (
    .clk, .rst_n, .accept,
    .name_byte(in_name_byte), .has_byte(in_has_byte), .is_last(in_is_last),
    .push_pending, .job_push, .job(job_w), .buf_wr
  );

  sih_queue u_queue (
    .clk, .rst_n, .push(job_push), .push_data(job_w),
    .pop(job_pop), .not_empty(q_not_empty), .pop_data(job_q)
  );

  sih_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_NAME_BYTES(MAX_NAME_BYTES)) u_back (
    .clk, .rst_n, .insert_limit(insert_limit_r), .buf_wr,
    .job_valid(q_not_empty), .job_in(job_q), .job_pop, .busy(back_busy),
    .res_valid(out_valid), .res_slot(out_slot), .res_is_new(out_is_new),
    .res_status(out_status)
  );

endmodule

/* hdl/sih_checker.sv */
// Port-level checks for the symbol intern hash table, bound to the top level.
module sih_checker import sih_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_is_new,
  input logic [1:0] out_status
);

  // Result strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result strobes");

  // The last byte of a name holds off the next transfer.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_is_last) |=> busy) else $error("not busy after last byte");

  // Only a successful insert reports a new name.
  a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_new) |-> (out_status == ST_OK)) else $error("new with error status");

  // No undefined status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL ||
                   out_status == ST_TOO_LONG)) else $error("bad status code");

endmodule

bind symbol_intern_hash_table sih_checker u_sih_checker (
  .clk, .rst_n, .start, .busy, .in_is_last, .out_valid, .out_is_new, .out_status
);
